>>> sv/two_class_priority_fifo_defines.svh
// Assertion macros shared by the two-class priority FIFO RTL.
`ifndef TWO_CLASS_PRIORITY_FIFO_DEFINES_SVH
`define TWO_CLASS_PRIORITY_FIFO_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked on every rising clk_i edge, masked while rst_ni is low.
`define TCPF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tcpf: property violated");
// Expression that must never be true.
`define TCPF_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("tcpf: forbidden condition seen");
`else
`define TCPF_ASSERT(lbl, prop)
`define TCPF_ASSERT_NEVER(lbl, expr)
`endif

`endif

>>> sv/tcpf_pkg.sv
// Shared types and constants of the two-class priority FIFO.
package tcpf_pkg;

  localparam int unsigned AddrW    = 32;
  localparam int unsigned SizeW    = 16;
  localparam int unsigned FlowW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // Request codes
  localparam logic CmdPush = 1'b0;
  localparam logic CmdPop  = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFlowLimit = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHoldHigh  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHoldLow   = 2'd2;

  localparam logic [FlowW-1:0] FlowLimitRst = 8'd4;

  typedef struct packed {
    logic             direction;
    logic [AddrW-1:0] address;
    logic [SizeW-1:0] size;
  } desc_t;

  typedef struct packed {
    logic  cmd;
    logic  is_high;
    desc_t desc;
  } req_t;

endpackage

>>> sv/tcpf_if.sv
// Channel interfaces: request in, result out, configuration write.
interface tcpf_req_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic                         is_high;
  logic                         direction;
  logic [tcpf_pkg::AddrW-1:0]   address;
  logic [tcpf_pkg::SizeW-1:0]   size;

  modport source (output valid, cmd, is_high, direction, address, size, input ready);
  modport sink   (input valid, cmd, is_high, direction, address, size, output ready);
endinterface

interface tcpf_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         got_item;
  logic                         out_direction;
  logic [tcpf_pkg::AddrW-1:0]   out_address;
  logic [tcpf_pkg::SizeW-1:0]   out_size;
  logic                         high_is_full;
  logic                         low_is_full;

  modport source (output valid, got_item, out_direction, out_address, out_size,
                  high_is_full, low_is_full, input ready);
  modport sink   (input valid, got_item, out_direction, out_address, out_size,
                  high_is_full, low_is_full, output ready);
endinterface

interface tcpf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tcpf_pkg::CfgIdxW-1:0]   index;
  logic [tcpf_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/two_class_priority_fifo.sv
// Two-class priority descriptor FIFO with a flow limit on the high class.
//
// Usage:
//   req_i  - one request per handshake: a push (cmd=0) of a descriptor into the
//            high or low class, or a pop (cmd=1) that serves high first.
//   rsp_o  - exactly one result per request: got_item, the popped descriptor
//            (zeros when nothing was returned) and both sticky full flags.
//   cfg_i  - register writes (flow_limit, hold_high, hold_low); ready is always
//            high. Write only while no request is in flight.
// Path: a request sits in the input register, its result in the result register.
//   Throughput: one request per cycle unless rsp_o stalls; the input register,
//   the pointer/flag logic plus the registered store read, and the result
//   register form a two-deep pipe, so every request finishes in a single pass.
// Reset: indices, flags and flow count clear, registers take their defaults.
//   Each store entry has a valid bit cleared by reset, so unwritten entries
//   read as zero; no clearing sweep is needed and req_i is ready at once.
// Stall: when rsp_o.ready is low the result register holds, one more request
//   is parked in the input register, then req_i.ready drops.
module two_class_priority_fifo #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcpf_req_if.sink    req_i,
  tcpf_rsp_if.source  rsp_o,
  tcpf_cfg_if.sink    cfg_i
);
  import tcpf_pkg::*;

  `include "two_class_priority_fifo_defines.svh"

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned OccW = IdxW + 1;
  localparam int unsigned TotW = IdxW + 2;

  typedef logic [IdxW-1:0] idx_t;

  function automatic idx_t wrap_next(input idx_t i);
    return (i == IdxW'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

  function automatic logic [OccW-1:0] occ(input idx_t wr, input idx_t rd);
    if (wr >= rd) begin
      return {1'b0, wr} - {1'b0, rd};
    end
    return {1'b0, wr} + OccW'(DEPTH) - {1'b0, rd};
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [FlowW-1:0] flow_limit_q;
  logic             hold_high_q, hold_low_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_limit_q <= FlowLimitRst;
      hold_high_q  <= 1'b0;
      hold_low_q   <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgFlowLimit: flow_limit_q <= cfg_i.data;
        CfgHoldHigh:  hold_high_q  <= cfg_i.data[0];
        CfgHoldLow:   hold_low_q   <= cfg_i.data[0];
        default:      ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic  item_vld_q;
  req_t  item_q;
  logic  out_vld_q;
  logic  a_fire;

  // The working stage moves on when the result register is free or drains.
  assign a_fire      = item_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !item_vld_q || a_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      item_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      item_q.cmd            <= req_i.cmd;
      item_q.is_high        <= req_i.is_high;
      item_q.desc.direction <= req_i.direction;
      item_q.desc.address   <= req_i.address;
      item_q.desc.size      <= req_i.size;
    end
  end

  // ---------------------------------------------------------------------------
  // Queue state
  // ---------------------------------------------------------------------------
  idx_t             hi_wr_q, hi_rd_q, lo_wr_q, lo_rd_q;
  idx_t             hi_wr_d, hi_rd_d, lo_wr_d, lo_rd_d;
  logic             hi_full_q, lo_full_q, hi_empty_q, lo_empty_q;
  logic             hi_full_d, lo_full_d, hi_empty_d, lo_empty_d;
  logic [FlowW-1:0] fc_q, fc_d;

  // Per-request decisions
  logic             hi_we, lo_we;
  idx_t             hi_slot, lo_slot;
  idx_t             hi_raddr, lo_raddr;
  logic             got_d, sel_high_d, route_high;
  logic [TotW-1:0]  total;

  assign hi_slot  = wrap_next(hi_wr_q);
  assign lo_slot  = wrap_next(lo_wr_q);
  // Address a pop would return from: current entry when held, next otherwise.
  assign hi_raddr = hold_high_q ? hi_rd_q : wrap_next(hi_rd_q);
  assign lo_raddr = hold_low_q  ? lo_rd_q : wrap_next(lo_rd_q);
  assign total    = TotW'(occ(hi_wr_q, hi_rd_q)) + TotW'(occ(lo_wr_q, lo_rd_q));

  assign route_high = !hi_empty_q && !hold_low_q
                      && ((fc_q < flow_limit_q) || hold_high_q);

  always_comb begin
    hi_wr_d    = hi_wr_q;
    hi_rd_d    = hi_rd_q;
    lo_wr_d    = lo_wr_q;
    lo_rd_d    = lo_rd_q;
    hi_full_d  = hi_full_q;
    lo_full_d  = lo_full_q;
    hi_empty_d = hi_empty_q;
    lo_empty_d = lo_empty_q;
    fc_d       = fc_q;
    hi_we      = 1'b0;
    lo_we      = 1'b0;
    got_d      = 1'b0;
    sel_high_d = 1'b0;

    if (item_q.cmd == CmdPush) begin
      if (item_q.is_high) begin
        // Slot collides with read index, or already flagged full: drop.
        if (hi_slot == hi_rd_q || hi_full_q) begin
          hi_full_d = 1'b1;
        end else begin
          hi_we   = 1'b1;
          hi_wr_d = hi_slot;
        end
        hi_empty_d = 1'b0;
      end else begin
        if (lo_slot == lo_rd_q || lo_full_q) begin
          lo_full_d = 1'b1;
        end else begin
          lo_we   = 1'b1;
          lo_wr_d = lo_slot;
        end
        lo_empty_d = 1'b0;
      end
      // Combined occupancy, taken before the push, trips both full flags.
      if ((total + 1'b1) >= TotW'(DEPTH)) begin
        hi_full_d = 1'b1;
        lo_full_d = 1'b1;
      end
    end else if (route_high) begin
      sel_high_d = 1'b1;
      if (!hold_high_q) begin
        fc_d = fc_q + 1'b1;
      end
      if (hi_rd_q == hi_wr_q && !hold_high_q) begin
        hi_empty_d = 1'b1;
      end else begin
        if (!hold_high_q) begin
          hi_rd_d   = hi_raddr;
          hi_full_d = 1'b0;
        end
        lo_full_d = 1'b0;
        got_d     = 1'b1;
      end
    end else begin
      // Low class served; the other class is not retried when this one is empty.
      fc_d = '0;
      if (lo_rd_q == lo_wr_q && !hold_low_q) begin
        lo_empty_d = 1'b1;
      end else begin
        if (!hold_low_q) begin
          lo_rd_d   = lo_raddr;
          lo_full_d = 1'b0;
        end
        hi_full_d = 1'b0;
        got_d     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_wr_q    <= '0;
      hi_rd_q    <= '0;
      lo_wr_q    <= '0;
      lo_rd_q    <= '0;
      hi_full_q  <= 1'b0;
      lo_full_q  <= 1'b0;
      hi_empty_q <= 1'b0;
      lo_empty_q <= 1'b0;
      fc_q       <= '0;
    end else if (a_fire) begin
      hi_wr_q    <= hi_wr_d;
      hi_rd_q    <= hi_rd_d;
      lo_wr_q    <= lo_wr_d;
      lo_rd_q    <= lo_rd_d;
      hi_full_q  <= hi_full_d;
      lo_full_q  <= lo_full_d;
      hi_empty_q <= hi_empty_d;
      lo_empty_q <= lo_empty_d;
      fc_q       <= fc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Descriptor stores, gated by a_fire: one write and one registered read per cycle each.
  // Valid bits make never-written entries read as zero.
  // ---------------------------------------------------------------------------
  desc_t            hi_mem [DEPTH];
  desc_t            lo_mem [DEPTH];
  logic [DEPTH-1:0] hi_vld_q, lo_vld_q;
  desc_t            hi_rdata_q, lo_rdata_q;
  logic             hi_rvld_q, lo_rvld_q;

  always_ff @(posedge clk_i) begin
    if (a_fire && hi_we) begin
      hi_mem[hi_slot] <= item_q.desc;
    end
    if (a_fire && lo_we) begin
      lo_mem[lo_slot] <= item_q.desc;
    end
    if (a_fire) begin
      hi_rdata_q <= hi_mem[hi_raddr];
      lo_rdata_q <= lo_mem[lo_raddr];
      hi_rvld_q  <= hi_vld_q[hi_raddr];
      lo_rvld_q  <= lo_vld_q[lo_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_vld_q <= '0;
      lo_vld_q <= '0;
    end else if (a_fire) begin
      if (hi_we) begin
        hi_vld_q[hi_slot] <= 1'b1;
      end
      if (lo_we) begin
        lo_vld_q[lo_slot] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic  got_q, sel_high_q;
  desc_t pop_desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      got_q      <= 1'b0;
      sel_high_q <= 1'b0;
    end else if (a_fire) begin
      out_vld_q  <= 1'b1;
      got_q      <= got_d;
      sel_high_q <= sel_high_d;
    end else if (rsp_o.ready) begin
      out_vld_q  <= 1'b0;
    end
  end

  always_comb begin
    pop_desc = '0;
    if (got_q) begin
      if (sel_high_q) begin
        pop_desc = hi_rvld_q ? hi_rdata_q : '0;
      end else begin
        pop_desc = lo_rvld_q ? lo_rdata_q : '0;
      end
    end
  end

  // Full flags in the state registers are the post-step values of the result.
  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.got_item      = got_q;
  assign rsp_o.out_direction = pop_desc.direction;
  assign rsp_o.out_address   = pop_desc.address;
  assign rsp_o.out_size      = pop_desc.size;
  assign rsp_o.high_is_full  = hi_full_q;
  assign rsp_o.low_is_full   = lo_full_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TCPF_ASSERT(a_got_only_on_pop, a_fire && got_d |-> item_q.cmd == CmdPop)
  `TCPF_ASSERT(a_hi_adv_clears_full,
               a_fire && sel_high_d && got_d && !hold_high_q |=> !hi_full_q)
  `TCPF_ASSERT(a_hi_empty_by_pop,
               $rose(hi_empty_q) |-> $past(a_fire && item_q.cmd == CmdPop))
  `TCPF_ASSERT_NEVER(a_idx_range,
                     hi_wr_q >= IdxW'(DEPTH - 1) && hi_wr_q != IdxW'(DEPTH - 1)
                     || lo_wr_q >= IdxW'(DEPTH - 1) && lo_wr_q != IdxW'(DEPTH - 1))

endmodule

>>> dv/tb_two_class_priority_fifo.sv
// Self-checking testbench for two_class_priority_fifo: directed and random request streams.
module tb_two_class_priority_fifo;
  timeunit 1ns;
  timeprecision 1ps;

  import tcpf_pkg::*;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned RspFreeze = 80;   // length of the one-time result-side hold-off
  localparam int unsigned RandPhases = 8;
  localparam int unsigned RandPerPhase = 215;

  // class index into the queue model
  localparam int ClsLow  = 0;
  localparam int ClsHigh = 1;

  typedef struct packed {
    logic             got_item;
    logic             out_direction;
    logic [AddrW-1:0] out_address;
    logic [SizeW-1:0] out_size;
    logic             high_is_full;
    logic             low_is_full;
  } fifo_result_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, channels
  // ---------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #6 clk_i = ~clk_i;

  tcpf_req_if req_if ();
  tcpf_rsp_if rsp_if ();
  tcpf_cfg_if cfg_if ();

  // Everything the testbench drives is held in local variables with a known
  // start value, so nothing floats before the first falling edge.
  logic                req_valid = 1'b0;
  req_t                req_item  = '0;
  logic                rsp_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  assign req_if.valid     = req_valid;
  assign req_if.cmd       = req_item.cmd;
  assign req_if.is_high   = req_item.is_high;
  assign req_if.direction = req_item.desc.direction;
  assign req_if.address   = req_item.desc.address;
  assign req_if.size      = req_item.desc.size;
  assign rsp_if.ready     = rsp_ready;
  assign cfg_if.valid     = cfg_valid;
  assign cfg_if.index     = cfg_index;
  assign cfg_if.data      = cfg_data;

  two_class_priority_fifo #(.DEPTH(DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // ---------------------------------------------------------------------------
  // Queue model. Register copies are owned by the stimulus process (written
  // only while idle); everything else is owned by the monitor.
  // ---------------------------------------------------------------------------
  logic [FlowW-1:0] flow_limit_reg = FlowLimitRst;
  bit               hold_high_reg  = 1'b0;
  bit               hold_low_reg   = 1'b0;

  desc_t            fifo_mem  [2][DEPTH];
  int unsigned      wr_idx    [2];
  int unsigned      rd_idx    [2];
  bit               full_flag [2];
  bit               empty_flag[2];
  logic [FlowW-1:0] flow_cnt;

  function automatic void clear_queues();
    for (int c = 0; c < 2; c++) begin
      for (int i = 0; i < DEPTH; i++) fifo_mem[c][i] = '0;
      wr_idx[c]     = 0;
      rd_idx[c]     = 0;
      full_flag[c]  = 1'b0;
      empty_flag[c] = 1'b0;   // empty flags come out of reset clear (stale)
    end
    flow_cnt = '0;
  endfunction

  function automatic int unsigned fill_level(int c);
    return (wr_idx[c] + DEPTH - rd_idx[c]) % DEPTH;
  endfunction

  // Push lands one past the write index; a sticky full flag drops it too.
  function automatic void store_desc(int c, desc_t d);
    int unsigned slot;
    slot = (wr_idx[c] + 1) % DEPTH;
    if (slot == rd_idx[c] || full_flag[c]) begin
      full_flag[c] = 1'b1;
    end else begin
      fifo_mem[c][slot] = d;
      wr_idx[c]         = slot;
    end
    empty_flag[c] = 1'b0;
  endfunction

  // A held queue never advances and replays whatever sits at the read index,
  // even an entry that was never written.
  function automatic bit take_desc(int c, bit held, output desc_t d);
    d = '0;
    if (rd_idx[c] == wr_idx[c] && !held) begin
      empty_flag[c] = 1'b1;
      return 1'b0;
    end
    if (!held) begin
      rd_idx[c]    = (rd_idx[c] + 1) % DEPTH;
      full_flag[c] = 1'b0;
    end
    d = fifo_mem[c][rd_idx[c]];
    return 1'b1;
  endfunction

  function automatic fifo_result_t serve_request(req_t r);
    fifo_result_t res;
    desc_t        d;
    bit           got;
    int unsigned  total;
    res = '0;
    d   = '0;
    got = 1'b0;
    if (r.cmd == CmdPush) begin
      // combined occupancy is taken before the push
      total = fill_level(ClsHigh) + fill_level(ClsLow);
      store_desc(r.is_high ? ClsHigh : ClsLow, r.desc);
      if (total + 1 >= DEPTH) begin
        full_flag[ClsHigh] = 1'b1;
        full_flag[ClsLow]  = 1'b1;
      end
    end else if (!empty_flag[ClsHigh] && !hold_low_reg &&
                 (flow_cnt < flow_limit_reg || hold_high_reg)) begin
      if (!hold_high_reg) flow_cnt = flow_cnt + 1'b1;
      if (take_desc(ClsHigh, hold_high_reg, d)) begin
        full_flag[ClsLow] = 1'b0;
        got = 1'b1;
      end
    end else begin
      // low class served; an empty pick does not fall back to high
      flow_cnt = '0;
      if (take_desc(ClsLow, hold_low_reg, d)) begin
        full_flag[ClsHigh] = 1'b0;
        got = 1'b1;
      end
    end
    res.got_item = got;
    if (got) begin
      res.out_direction = d.direction;
      res.out_address   = d.address;
      res.out_size      = d.size;
    end
    res.high_is_full = full_flag[ClsHigh];
    res.low_is_full  = full_flag[ClsLow];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------------
  req_t         req_backlog[$];      // requests waiting for the driver
  fifo_result_t pending_results[$];  // predicted results, oldest first
  int unsigned  reqs_queued   = 0;   // stimulus side
  int unsigned  reqs_sent     = 0;   // driver side
  int unsigned  reqs_taken    = 0;   // monitor side
  int unsigned  results_seen  = 0;   // monitor side
  int unsigned  descs_returned = 0;
  int unsigned  full_results  = 0;
  int unsigned  fail_count    = 0;
  int unsigned  phases_run    = 0;

  bit tx_idle_en    = 1'b0;
  bit rx_idle_en    = 1'b0;
  bit rsp_freeze_go = 1'b0;
  bit rsp_frozen    = 1'b0;

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: changes on the falling edge, moves on once the current
  // request has been taken at a rising edge.
  // ---------------------------------------------------------------------------
  int unsigned tx_gap_left = 0;

  always @(negedge clk_i) begin
    if (rst_ni && reqs_taken == reqs_sent) begin
      if (tx_gap_left != 0) begin
        tx_gap_left--;
        req_valid <= 1'b0;
      end else if (req_backlog.size() != 0) begin
        req_item  <= req_backlog.pop_front();
        req_valid <= 1'b1;
        reqs_sent++;
        tx_gap_left = tx_idle_en ? pick_gap() : 0;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Result-side ready: high, random stalls when rx idling is on, or the long freeze when asked for.
  int unsigned rx_gap_left = 0;

  always @(negedge clk_i) begin
    if (rsp_frozen) begin
      rsp_ready <= 1'b0;
    end else if (!rx_idle_en) begin
      rsp_ready <= 1'b1;
    end else if (rx_gap_left != 0) begin
      rx_gap_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
      rx_gap_left = pick_gap();
    end
  end

  // The long hold-off, counted here so the sender keeps pushing meanwhile.
  initial begin
    wait (rsp_freeze_go);
    @(posedge clk_i);
    rsp_frozen <= 1'b1;
    repeat (RspFreeze) @(posedge clk_i);
    rsp_frozen <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each taken request, checks each taken result.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [AddrW-1:0] want,
                                      logic [AddrW-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    req_t         taken;
    fifo_result_t want;
    if (!rst_ni) begin
      clear_queues();
    end else begin
      if (req_if.valid && req_if.ready) begin
        taken.cmd            = req_if.cmd;
        taken.is_high        = req_if.is_high;
        taken.desc.direction = req_if.direction;
        taken.desc.address   = req_if.address;
        taken.desc.size      = req_if.size;
        pending_results.push_back(serve_request(taken));
        reqs_taken++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        results_seen++;
        if (rsp_if.got_item === 1'b1) descs_returned++;
        if (rsp_if.high_is_full === 1'b1 || rsp_if.low_is_full === 1'b1) full_results++;
        if (pending_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("got_item",      want.got_item,      rsp_if.got_item);
          check_field("out_direction", want.out_direction, rsp_if.out_direction);
          check_field("out_address",   want.out_address,   rsp_if.out_address);
          check_field("out_size",      want.out_size,      rsp_if.out_size);
          check_field("high_is_full",  want.high_is_full,  rsp_if.high_is_full);
          check_field("low_is_full",   want.low_is_full,   rsp_if.low_is_full);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic req_t push_req(bit hi, bit dir, logic [AddrW-1:0] addr,
                                    logic [SizeW-1:0] sz);
    req_t r;
    r.cmd            = CmdPush;
    r.is_high        = hi;
    r.desc.direction = dir;
    r.desc.address   = addr;
    r.desc.size      = sz;
    return r;
  endfunction

  // Pop with junk in the ignored fields.
  function automatic req_t pop_req();
    req_t r;
    r     = push_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom(),
                     SizeW'($urandom()));
    r.cmd = CmdPop;
    return r;
  endfunction

  function automatic req_t random_req(int unsigned push_pct);
    logic [AddrW-1:0] addr;
    logic [SizeW-1:0] sz;
    case ($urandom_range(0, 9))
      0:       addr = '0;
      1:       addr = '1;
      default: addr = $urandom();
    endcase
    case ($urandom_range(0, 9))
      0:       sz = '0;
      1:       sz = '1;
      default: sz = SizeW'($urandom_range(0, 65535));
    endcase
    if ($urandom_range(0, 99) < push_pct)
      return push_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), addr, sz);
    return pop_req();
  endfunction

  task automatic queue_req(req_t r);
    req_backlog.push_back(r);
    reqs_queued++;
  endtask

  // Sender pause: nothing goes out until every predicted result is back.
  task automatic wait_drained();
    while (results_seen != reqs_queued) @(negedge clk_i);
  endtask

  task automatic write_regs(logic [FlowW-1:0] limit, bit hh, bit hl);
    logic [CfgIdxW-1:0]  idx[3];
    logic [CfgDataW-1:0] val[3];
    idx[0] = CfgFlowLimit;
    idx[1] = CfgHoldHigh;
    idx[2] = CfgHoldLow;
    val[0] = limit;
    // hold registers only look at bit 0; upper bits get noise
    val[1] = {7'($urandom_range(0, 127)), hh};
    val[2] = {7'($urandom_range(0, 127)), hl};
    for (int k = 0; k < 3; k++) begin
      @(negedge clk_i);
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk_i); while (!cfg_if.ready);
    end
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    flow_limit_reg = limit;
    hold_high_reg  = hh;
    hold_low_reg   = hl;
  endtask

  task automatic begin_phase(logic [FlowW-1:0] limit, bit hh, bit hl, bit tx_idle,
                             bit rx_idle);
    wait_drained();
    write_regs(limit, hh, hl);
    tx_idle_en <= tx_idle;
    rx_idle_en <= rx_idle;
    phases_run++;
    @(posedge clk_i);
  endtask

  initial begin
    logic [FlowW-1:0] limit;
    bit               hh;
    bit               hl;
    int unsigned      push_pct;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // High class held from reset: pops replay slot 0, which was never written.
    begin_phase(FlowLimitRst, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_req(pop_req());
    queue_req(push_req(1'b1, 1'b1, '1, '1));
    queue_req(pop_req());
    queue_req(pop_req());
    queue_req(push_req(1'b0, 1'b1, 32'hA5A5_5A5A, 16'h1234));

    // Low class held: every pop goes low and replays, high service blocked.
    begin_phase(FlowLimitRst, 1'b0, 1'b1, 1'b0, 1'b1);
    queue_req(pop_req());
    queue_req(push_req(1'b0, 1'b0, 32'h0000_0001, 16'h8000));
    queue_req(pop_req());
    queue_req(push_req(1'b1, 1'b0, '0, '0));
    queue_req(pop_req());

    // Plain service: high drains, stale empty flag on high, then low.
    begin_phase(FlowLimitRst, 1'b0, 1'b0, 1'b1, 1'b1);
    repeat (4) queue_req(pop_req());
    queue_req(push_req(1'b1, 1'b0, 32'h8000_0000, 16'h0001));
    queue_req(push_req(1'b0, 1'b1, 32'h7FFF_FFFF, 16'hFFFE));
    repeat (4) queue_req(pop_req());

    // Flow limit of zero: high is never served without a hold.
    begin_phase('0, 1'b0, 1'b0, 1'b1, 1'b1);
    queue_req(push_req(1'b1, 1'b1, 32'hDEAD_0001, 16'h00FF));
    queue_req(push_req(1'b0, 1'b0, 32'h0BAD_F00D, 16'hFF00));
    repeat (3) queue_req(pop_req());

    // Backpressure: result side frozen while a burst of pushes overfills both
    // classes, so the input stalls and the full flags and drops get exercised.
    begin_phase(8'd2, 1'b0, 1'b0, 1'b0, 1'b0);
    rsp_freeze_go <= 1'b1;
    repeat (24) queue_req(random_req(100));
    repeat (24) queue_req(random_req(0));

    // Random phases over a spread of register settings, extremes included.
    for (int p = 0; p < RandPhases; p++) begin
      hh       = 1'b0;
      hl       = 1'b0;
      push_pct = 50;
      case (p)
        0: begin limit = FlowLimitRst; push_pct = 60; end
        1: limit = '0;
        2: begin limit = '1; push_pct = 55; end
        3: begin limit = 8'd1; push_pct = 45; end
        4: begin limit = FlowW'($urandom_range(2, 8)); hh = 1'b1; end
        5: begin limit = FlowW'($urandom_range(2, 8)); hl = 1'b1; end
        6: begin limit = FlowW'($urandom_range(0, 255)); hh = 1'b1; hl = 1'b1; end
        default: begin limit = 8'd3; push_pct = 40; end
      endcase
      // first phase runs with no idling at all
      begin_phase(limit, hh, hl, p != 0, p != 0 && p != 3);
      for (int n = 0; n < RandPerPhase; n++) begin
        // bursts that push the occupancy toward full or empty
        if (n % 60 < 20) queue_req(random_req(push_pct + 25));
        else if (n % 60 < 40) queue_req(random_req(push_pct - 25));
        else queue_req(random_req(push_pct));
      end
    end

    wait_drained();
    repeat (10) @(negedge clk_i);

    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
    end
    $display("Ran %0d requests over %0d register settings; %0d pops returned a descriptor,",
             reqs_taken, phases_run, descs_returned);
    $display("%0d results carried a full flag; one long result stall under load.",
             full_results);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/tcpf_pkg.sv
sv/tcpf_if.sv
sv/two_class_priority_fifo.sv
dv/tb_two_class_priority_fifo.sv
